FILE: hw/rtl/blsc_pkg.sv
package blsc_pkg;

	localparam int NUM_LEDS  = 4;
	localparam int LED_W     = 2;
	localparam int SPEED_W   = 4;
	localparam int TICK_W    = 10;

	localparam logic [SPEED_W-1:0] SPEED_MAX   = 4'd9;
	localparam logic [SPEED_W-1:0] SPEED_MIN   = 4'd0;
	localparam logic [SPEED_W-1:0] RESET_SPEED = 4'd5;

	localparam logic [LED_W-1:0] LED_LAST = LED_W'(NUM_LEDS - 1);

	// command characters
	localparam logic [7:0] CH_HELP    = 8'h3F; // '?'
	localparam logic [7:0] CH_ZERO    = 8'h30; // '0'
	localparam logic [7:0] CH_NINE    = 8'h39; // '9'
	localparam logic [7:0] CH_STOP_LO = 8'h78; // 'x'
	localparam logic [7:0] CH_STOP_UP = 8'h58; // 'X'

	typedef enum logic [1:0] {
		MODE_RX   = 2'd0,
		MODE_TICK = 2'd1,
		MODE_JOY  = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [TICK_W-1:0]  tick_count;
		logic [LED_W-1:0]   led_pos;
		logic               moving_down;
		logic               up_was_pressed;
		logic               down_was_pressed;
	} state_t;

	typedef struct packed {
		logic [LED_W-1:0]   led_index;
		logic [SPEED_W-1:0] speed_level;
		logic               speed_changed;
		logic               help_request;
		logic               watchdog_stop;
		logic               invalid_command;
	} result_t;

endpackage

FILE: hw/rtl/bouncing_led_speed_controller.sv
// One request in, one result out, one request per clock sustained while
// the consumer keeps out_ready high. The state update and result are worked
// out in the cycle a request is accepted and the result is held in an output
// register; in_ready stays high while that register is empty or being taken,
// so a stalled consumer only costs cycles once the single output slot is
// full. out_valid is registered and rises in the cycle after acceptance.
module bouncing_led_speed_controller (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [7:0] rx_byte,
	input  logic       joy_up_level,
	input  logic       joy_down_level,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] led_index,
	output logic [3:0] speed_level,
	output logic       speed_changed,
	output logic       help_request,
	output logic       watchdog_stop,
	output logic       invalid_command
);
	import blsc_pkg::*;

	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    out_valid_q;
	logic    accept;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	blsc_step u_step (
		.cur            (state_q),
		.mode           (mode),
		.rx_byte        (rx_byte),
		.joy_up_level   (joy_up_level),
		.joy_down_level (joy_down_level),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.speed            <= RESET_SPEED;
			state_q.tick_count       <= '0;
			state_q.led_pos          <= '0;
			state_q.moving_down      <= 1'b0;
			state_q.up_was_pressed   <= 1'b0;
			state_q.down_was_pressed <= 1'b0;
			out_valid_q              <= 1'b0;
		end else begin
			if (accept) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign led_index       = res_q.led_index;
	assign speed_level     = res_q.speed_level;
	assign speed_changed   = res_q.speed_changed;
	assign help_request    = res_q.help_request;
	assign watchdog_stop   = res_q.watchdog_stop;
	assign invalid_command = res_q.invalid_command;

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.speed <= SPEED_MAX)
		else $error("speed left its range");

	a_pulse_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0({speed_changed, help_request, watchdog_stop,
		                          invalid_command}))
		else $error("more than one pulse in a result");

	a_accept_valid: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted request produced no result");

	a_tick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode == MODE_TICK |=> !(speed_changed || help_request ||
		                                   watchdog_stop || invalid_command))
		else $error("tick raised a pulse");

	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (led_index == state_q.led_pos &&
		                 speed_level == state_q.speed))
		else $error("result out of step with state");

endmodule

FILE: hw/rtl/blsc_step.sv
module blsc_step (
	input  blsc_pkg::state_t  cur,
	input  logic [1:0]        mode,
	input  logic [7:0]        rx_byte,
	input  logic              joy_up_level,
	input  logic              joy_down_level,
	output blsc_pkg::state_t  nxt,
	output blsc_pkg::result_t res
);
	import blsc_pkg::*;

	logic [SPEED_W-1:0] digit;
	logic [SPEED_W:0]   spd_up;
	logic [SPEED_W-1:0] spd_mid;
	logic [TICK_W-1:0]  cnt_inc;
	logic [TICK_W-1:0]  period;
	logic               md;

	always_comb begin
		nxt     = cur;
		res     = '0;
		digit   = SPEED_W'(rx_byte - CH_ZERO);
		spd_up  = {1'b0, cur.speed} + (SPEED_W+1)'(1);
		spd_mid = cur.speed;
		cnt_inc = cur.tick_count + TICK_W'(1);
		period  = TICK_W'(1) << cur.speed;
		md      = cur.moving_down;

		case (mode_t'(mode))
			MODE_RX: begin
				if (rx_byte == CH_HELP) begin
					res.help_request = 1'b1;
				end else if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
					// out-of-range digit is dropped silently
					if (digit >= SPEED_MIN && digit <= SPEED_MAX) begin
						nxt.speed         = digit;
						res.speed_changed = 1'b1;
					end
				end else if (rx_byte == CH_STOP_LO || rx_byte == CH_STOP_UP) begin
					res.watchdog_stop = 1'b1;
				end else begin
					res.invalid_command = 1'b1;
				end
			end
			MODE_TICK: begin
				nxt.tick_count = cnt_inc;
				if (cnt_inc >= period) begin
					nxt.tick_count = '0;
					if (cur.led_pos >= LED_LAST) begin
						md = 1'b1;
					end else if (cur.led_pos == '0) begin
						md = 1'b0;
					end
					nxt.moving_down = md;
					if (md) begin
						nxt.led_pos = (cur.led_pos != '0) ? cur.led_pos - LED_W'(1) : '0;
					end else begin
						nxt.led_pos = cur.led_pos + LED_W'(1);
					end
				end
			end
			MODE_JOY: begin
				// up release first, then down release on the updated speed
				if (cur.up_was_pressed && !joy_up_level &&
				    spd_up <= {1'b0, SPEED_MAX}) begin
					spd_mid           = SPEED_W'(spd_up);
					res.speed_changed = 1'b1;
				end
				nxt.speed = spd_mid;
				if (cur.down_was_pressed && !joy_down_level && spd_mid != '0 &&
				    (spd_mid - SPEED_W'(1)) >= SPEED_MIN) begin
					nxt.speed         = spd_mid - SPEED_W'(1);
					res.speed_changed = 1'b1;
				end
				nxt.up_was_pressed   = joy_up_level;
				nxt.down_was_pressed = joy_down_level;
			end
			default: begin
			end
		endcase

		res.led_index   = nxt.led_pos;
		res.speed_level = nxt.speed;
	end

endmodule
